[src/particle_motion_bounce_colour_assert.svh]
// Assertion macros for the particle motion block.
`ifndef PARTICLE_MOTION_BOUNCE_COLOUR_ASSERT_SVH
`define PARTICLE_MOTION_BOUNCE_COLOUR_ASSERT_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define PMBC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication.
`define PMBC_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define PMBC_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define PMBC_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

[src/pmbc_pkg.sv]
// Shared constants, types and saturation helpers for the particle motion block.
`default_nettype none
package pmbc_pkg;

    localparam int FRAC_BITS_DEF = 16;

    // Pipeline depths
    localparam int AXIS_LAT = 5;
    localparam int DIV_LAT  = 17;
    localparam int SQRT_LAT = 17;
    localparam int TOTAL_LAT = AXIS_LAT + 1 + DIV_LAT;

    localparam logic [16:0] COLOUR_ONE = 17'd65536;
    localparam logic [16:0] COLOUR_MID = 17'd32768;

    typedef enum logic [2:0] {
        REG_ACCEL_X   = 3'd0,
        REG_ACCEL_Y   = 3'd1,
        REG_TIME_STEP = 3'd2,
        REG_LIMIT_X   = 3'd3,
        REG_LIMIT_Y   = 3'd4
    } cfg_reg_t;

    function automatic logic signed [63:0] sx64(input logic signed [31:0] v);
        return {{32{v[31]}}, v};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'h7fff_ffff;
        else if (v < -64'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage
`default_nettype wire

[src/pmbc_axis.sv]
// One axis: kinematic update, saturation, clamp and bounce in five stages.
`default_nettype none
module pmbc_axis #(
    parameter int FRAC_BITS = pmbc_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               en,
    input  wire logic signed [31:0] accel,
    input  wire logic        [30:0] dt,
    input  wire logic        [30:0] lim,
    input  wire logic signed [31:0] pos,
    input  wire logic signed [31:0] vel,
    output logic signed [31:0]      np,
    output logic signed [31:0]      nv
);
    import pmbc_pkg::*;

    logic signed [31:0] dt_s;
    logic signed [32:0] lim_s;
    logic signed [31:0] half_next, dv_next, dp_next;
    logic signed [31:0] q_next, w_next;

    logic signed [31:0] p1_reg, v1_reg;
    logic signed [63:0] adt1_reg;
    logic signed [31:0] p2_reg, vh2_reg, w2_reg;
    logic signed [31:0] p3_reg, w3_reg;
    logic signed [63:0] prod3_reg;
    logic signed [31:0] q4_reg, w4_reg;
    logic signed [31:0] np_reg, nv_reg;

    assign dt_s  = $signed({1'b0, dt});
    assign lim_s = $signed({2'b00, lim});

    always_comb
    begin
        half_next = sat32(adt1_reg >>> (FRAC_BITS + 1));
        dv_next   = sat32(adt1_reg >>> FRAC_BITS);
        dp_next   = sat32(prod3_reg >>> FRAC_BITS);
    end

    // clamp and bounce
    always_comb
    begin
        q_next = q4_reg;
        w_next = w4_reg;
        if ($signed({q4_reg[31], q4_reg}) > lim_s)
        begin
            q_next = lim_s[31:0];
            if (w4_reg >= 0)
                w_next = -w4_reg;
        end
        else if ($signed({q4_reg[31], q4_reg}) < -lim_s)
        begin
            q_next = -lim_s[31:0];
            if (w4_reg <= 0)
                w_next = sat32(-sx64(w4_reg));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_reg    <= pos;
            v1_reg    <= vel;
            adt1_reg  <= accel * dt_s;
            p2_reg    <= p1_reg;
            vh2_reg   <= sat32(sx64(v1_reg) + sx64(half_next));
            w2_reg    <= sat32(sx64(v1_reg) + sx64(dv_next));
            p3_reg    <= p2_reg;
            w3_reg    <= w2_reg;
            prod3_reg <= vh2_reg * dt_s;
            q4_reg    <= sat32(sx64(p3_reg) + sx64(dp_next));
            w4_reg    <= w3_reg;
            np_reg    <= q_next;
            nv_reg    <= w_next;
        end
    end

    assign np = np_reg;
    assign nv = nv_reg;
endmodule
`default_nettype wire

[src/pmbc_div.sv]
// Pipelined restoring divider, one quotient bit per stage: num * 2^15 / den.
`default_nettype none
module pmbc_div (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [31:0] num,
    input  wire logic [30:0] den,
    output logic      [16:0] quo
);
    import pmbc_pkg::*;

    logic [46:0] r_reg [DIV_LAT];
    logic [16:0] q_reg [DIV_LAT];

    for (genvar j = 0; j < DIV_LAT; j++)
    begin : g_stage
        localparam int K = DIV_LAT - 1 - j;
        logic [46:0] rin, dsh;
        logic [16:0] qin;
        logic        ge;
        always_comb
        begin
            if (j == 0)
            begin
                rin = {num, 15'd0};
                qin = '0;
            end
            else
            begin
                rin = r_reg[(j == 0) ? 0 : j - 1];
                qin = q_reg[(j == 0) ? 0 : j - 1];
            end
            dsh = {16'd0, den} << K;
            ge  = rin >= dsh;
        end
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                r_reg[j] <= ge ? rin - dsh : rin;
                q_reg[j] <= qin | ({16'd0, ge} << K);
            end
        end
    end

    assign quo = q_reg[DIV_LAT-1];
endmodule
`default_nettype wire

[src/pmbc_sqrt.sv]
// Speed for blue: sum of squares, scale, then pipelined integer square root.
`default_nettype none
module pmbc_sqrt #(
    parameter int FRAC_BITS = pmbc_pkg::FRAC_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        en,
    input  wire logic [63:0] sq_x,
    input  wire logic [63:0] sq_y,
    output logic      [16:0] root
);
    import pmbc_pkg::*;

    localparam int NIT = SQRT_LAT - 1;
    localparam int SH  = 32 - 2 * FRAC_BITS;
    localparam logic [63:0] ONE_SQ = 64'd1 << (2 * FRAC_BITS);

    logic [63:0] s, t;
    logic [31:0] n_reg   [SQRT_LAT];
    logic [31:0] res_reg [SQRT_LAT];
    logic        cap_reg [SQRT_LAT];

    assign s = sq_x + sq_y;

    if (SH >= 0)
    begin : g_shl
        assign t = s << SH;
    end
    else
    begin : g_shr
        assign t = s >> (-SH);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n_reg[0]   <= t[31:0];
            res_reg[0] <= '0;
            cap_reg[0] <= s >= ONE_SQ;
        end
    end

    for (genvar i = 1; i < SQRT_LAT; i++)
    begin : g_iter
        localparam logic [32:0] BIT = 33'd1 << (2 * (NIT - i));
        logic [32:0] sum;
        logic        ge;
        assign sum = {1'b0, res_reg[i-1]} + BIT;
        assign ge  = {1'b0, n_reg[i-1]} >= sum;
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                n_reg[i]   <= ge ? n_reg[i-1] - sum[31:0] : n_reg[i-1];
                res_reg[i] <= ge ? (res_reg[i-1] >> 1) + BIT[31:0] : res_reg[i-1] >> 1;
                cap_reg[i] <= cap_reg[i-1];
            end
        end
    end

    assign root = cap_reg[SQRT_LAT-1] ? COLOUR_ONE : {1'b0, res_reg[SQRT_LAT-1][15:0]};
endmodule
`default_nettype wire

[src/particle_motion_bounce_colour.sv]
// Top level of the particle motion block: config, pipeline control, colour.
//
// One request per point: pos_x/pos_y/vel_x/vel_y in signed fixed point and
// want_colour. The result request carries the moved, clamped position, the
// velocity after a wall bounce and, when asked for, the colour red/green/blue
// with colour_valid set.
// Both channels use valid/stall; a request moves when valid is high and
// stall is low. Registers are written through cfg_we/cfg_index/cfg_data; the user
// must write them only while no request is in flight, the block does not enforce it.
// A point passes the axis stages, the numerator register and the divider
// to the output register. Throughput is one point per cycle unless the receiver
// stalls; the whole 23-stage pipeline, set by the 17-stage divider for red/green,
// advances together. When the receiver stalls with a result waiting, the pipeline
// freezes and in_stall goes high in the same cycle; empty slots are not squeezed.
// Reset (rst_n low) clears vld_reg, not want_reg, and loads the register defaults.
`default_nettype none
module particle_motion_bounce_colour #(
    parameter int FRAC_BITS = pmbc_pkg::FRAC_BITS_DEF
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // configuration
    input  wire logic               cfg_we,
    input  wire logic [2:0]         cfg_index,
    input  wire logic [31:0]        cfg_data,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [31:0] pos_x,
    input  wire logic signed [31:0] pos_y,
    input  wire logic signed [31:0] vel_x,
    input  wire logic signed [31:0] vel_y,
    input  wire logic               want_colour,
    // output channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [31:0]      new_pos_x,
    output logic signed [31:0]      new_pos_y,
    output logic signed [31:0]      new_vel_x,
    output logic signed [31:0]      new_vel_y,
    output logic [16:0]             red,
    output logic [16:0]             green,
    output logic [16:0]             blue,
    output logic                    colour_valid
);
    import pmbc_pkg::*;

    localparam int TAIL = TOTAL_LAT - AXIS_LAT;  // stages after the axis units

    logic signed [31:0] accel_x_reg, accel_y_reg;
    logic [30:0]        time_step_reg, limit_x_reg, limit_y_reg;

    logic [TOTAL_LAT-1:0] vld_reg;
    logic [TOTAL_LAT-1:0] want_reg;
    logic                 adv;

    logic signed [31:0] npx, npy, nvx, nvy;
    logic signed [31:0] px_reg [TAIL];
    logic signed [31:0] py_reg [TAIL];
    logic signed [31:0] vx_reg [TAIL];
    logic signed [31:0] vy_reg [TAIL];

    logic [31:0] numx_reg, numy_reg;
    logic [63:0] sqx_reg, sqy_reg;
    logic signed [63:0] sqx_full, sqy_full;
    logic [16:0] quo_x, quo_y, root;
    logic signed [32:0] sumx, sumy;

    // Whole pipeline moves unless a finished result is held by the receiver.
    assign adv      = !(vld_reg[TOTAL_LAT-1] && out_stall);
    assign in_stall = !adv;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            accel_x_reg   <= '0;
            accel_y_reg   <= '0;
            time_step_reg <= 31'd7;
            limit_x_reg   <= 31'd65536;
            limit_y_reg   <= 31'd32768;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ACCEL_X:   accel_x_reg   <= cfg_data;
                REG_ACCEL_Y:   accel_y_reg   <= cfg_data;
                REG_TIME_STEP: time_step_reg <= cfg_data[30:0];
                REG_LIMIT_X:   limit_x_reg   <= cfg_data[30:0];
                REG_LIMIT_Y:   limit_y_reg   <= cfg_data[30:0];
                default:       ;
            endcase
        end
    end

    // valid and colour request travel with the data
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[TOTAL_LAT-2:0], in_valid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            want_reg <= {want_reg[TOTAL_LAT-2:0], want_colour};
    end

    pmbc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_x (
        .clk(clk), .en(adv), .accel(accel_x_reg), .dt(time_step_reg),
        .lim(limit_x_reg), .pos(pos_x), .vel(vel_x), .np(npx), .nv(nvx)
    );

    pmbc_axis #(.FRAC_BITS(FRAC_BITS)) u_axis_y (
        .clk(clk), .en(adv), .accel(accel_y_reg), .dt(time_step_reg),
        .lim(limit_y_reg), .pos(pos_y), .vel(vel_y), .np(npy), .nv(nvy)
    );

    // Clamped position lies in [-lim, lim], so p + lim fits 32 bits unsigned.
    assign sumx = $signed({npx[31], npx}) + $signed({2'b00, limit_x_reg});
    assign sumy = $signed({npy[31], npy}) + $signed({2'b00, limit_y_reg});

    // full 64-bit squares of the new velocities
    assign sqx_full = nvx * nvx;
    assign sqy_full = nvy * nvy;

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            numx_reg <= sumx[31:0];
            numy_reg <= sumy[31:0];
            sqx_reg  <= $unsigned(sqx_full);
            sqy_reg  <= $unsigned(sqy_full);
            px_reg[0] <= npx;
            py_reg[0] <= npy;
            vx_reg[0] <= nvx;
            vy_reg[0] <= nvy;
            for (int k = 1; k < TAIL; k++)
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
                vx_reg[k] <= vx_reg[k-1];
                vy_reg[k] <= vy_reg[k-1];
            end
        end
    end

    pmbc_div u_div_x (
        .clk(clk), .en(adv), .num(numx_reg), .den(limit_x_reg), .quo(quo_x)
    );

    pmbc_div u_div_y (
        .clk(clk), .en(adv), .num(numy_reg), .den(limit_y_reg), .quo(quo_y)
    );

    pmbc_sqrt #(.FRAC_BITS(FRAC_BITS)) u_sqrt (
        .clk(clk), .en(adv), .sq_x(sqx_reg), .sq_y(sqy_reg), .root(root)
    );

    // output register is the last pipeline stage
    assign out_valid    = vld_reg[TOTAL_LAT-1];
    assign colour_valid = want_reg[TOTAL_LAT-1];
    assign new_pos_x    = px_reg[TAIL-1];
    assign new_pos_y    = py_reg[TAIL-1];
    assign new_vel_x    = vx_reg[TAIL-1];
    assign new_vel_y    = vy_reg[TAIL-1];

    // zero limit: colour sits at the midpoint
    always_comb
    begin
        red   = '0;
        green = '0;
        blue  = '0;
        if (want_reg[TOTAL_LAT-1])
        begin
            red   = (limit_x_reg == '0) ? COLOUR_MID : quo_x;
            green = (limit_y_reg == '0) ? COLOUR_MID : quo_y;
            blue  = root;
        end
    end

`include "particle_motion_bounce_colour_assert.svh"

    `PMBC_ASSERT_IMP(a_stall_only_when_held, clk, rst_n, in_stall, out_valid && out_stall)
    `PMBC_ASSERT_NXT(a_result_arrives, clk, rst_n, vld_reg[TOTAL_LAT-2] && adv, out_valid)
    `PMBC_ASSERT_IMP(a_no_colour_zero, clk, rst_n, out_valid && !colour_valid, red == '0 && green == '0 && blue == '0)
    `PMBC_ASSERT_IMP(a_colour_range, clk, rst_n, out_valid, red <= COLOUR_ONE && green <= COLOUR_ONE && blue <= COLOUR_ONE)

endmodule
`default_nettype wire
